// ===== hdl/bfa_pkg.sv =====
package bfa_pkg;

   // field widths
   localparam int ADDR_W      = 52;
   localparam int CNT_W       = 16;
   localparam int IDX_W       = 16;   // frame index, bounded by the 16 bit frame total
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = 6;
   localparam int WRD_W       = IDX_W - BIT_W;
   localparam int RUN_W       = BIT_W + 1;
   localparam int FRAME_SHIFT = 12;   // 4 KiB frames
   localparam int CSR_IDX_W   = 1;

   localparam int DEF_MAX_FRAMES = 32768;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASE_ADDRESS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_TOTAL  = 1'd1;

   typedef enum logic [1:0] {
      ST_ALLOCATED    = 2'd0,
      ST_ALLOC_FAIL   = 2'd1,
      ST_FREED        = 2'd2,
      ST_FREE_IGNORED = 2'd3
   } status_type;

   // per-word outcome of the run search
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [WRD_W-1:0] word;
      logic [IDX_W-1:0] end_idx;
   } scan_res_type;

endpackage

// ===== hdl/bfa_map_ram.sv =====
module bfa_map_ram
   import bfa_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_FRAMES / WORD_BITS,
   parameter int AW    = 9
) (
   input  logic                 clock,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0] mem_ff [0:DEPTH-1];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bfa_run_finder.sv =====
module bfa_run_finder
   import bfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 active,
   input  logic                 in_valid,
   input  logic [WRD_W-1:0]     in_word,
   input  logic [WORD_BITS-1:0] in_data,
   input  logic [IDX_W-1:0]     total,
   input  logic [CNT_W-1:0]     count,
   output scan_res_type         res
);

   logic [IDX_W:0]       rem;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] masked;
   // position+1 of the nearest used frame at or below each bit, 0 if none
   logic [RUN_W-1:0]     pfx [0:BIT_W][0:WORD_BITS-1];

   logic                 s1_valid_ff;
   logic [WRD_W-1:0]     s1_word_ff;
   logic [WORD_BITS-1:0] s1_allfree_ff;
   logic [RUN_W-1:0]     s1_rl_ff [0:WORD_BITS-1];
   logic [CNT_W-1:0]     carry_ff;
   logic [CNT_W-1:0]     carry_in;

   logic [WORD_BITS-1:0] hit;
   logic [BIT_W-1:0]     pos;
   logic                 out_valid;

   // stage 1: mask frames past the total, prefix search inside the word
   always_comb begin
      rem = (IDX_W+1)'(total) - (IDX_W+1)'({in_word, BIT_W'(0)});
      if (rem >= (IDX_W+1)'(WORD_BITS)) begin
         valid_mask = '1;
      end else begin
         valid_mask = ~({WORD_BITS{1'b1}} << rem[BIT_W-1:0]);
      end
      masked = in_data & valid_mask;
      for (int b = 0; b < WORD_BITS; b++) begin
         pfx[0][b] = masked[b] ? '0 : RUN_W'(b + 1);
      end
      for (int l = 0; l < BIT_W; l++) begin
         for (int b = 0; b < WORD_BITS; b++) begin
            if (b >= (1 << l) && pfx[l][b] == '0) begin
               pfx[l+1][b] = pfx[l][(b >= (1 << l)) ? b - (1 << l) : b];
            end else begin
               pfx[l+1][b] = pfx[l][b];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid & active;
      end
   end

   always_ff @(posedge clock) begin
      s1_word_ff <= in_word;
      for (int b = 0; b < WORD_BITS; b++) begin
         s1_allfree_ff[b] <= (pfx[BIT_W][b] == '0);
         s1_rl_ff[b]      <= RUN_W'(b + 1) - pfx[BIT_W][b];
      end
   end

   // stage 2: add the run carried in from lower words, find the first fit
   assign out_valid = s1_valid_ff & active;

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         if (s1_allfree_ff[b]) begin
            hit[b] = ((CNT_W+1)'(carry_ff) + (CNT_W+1)'(b + 1)) >= (CNT_W+1)'(count);
         end else begin
            hit[b] = CNT_W'(s1_rl_ff[b]) >= count;
         end
      end
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (hit[b]) begin
            pos = BIT_W'(b);
         end
      end
      if (!active) begin
         carry_in = '0;
      end else if (s1_valid_ff) begin
         if (s1_allfree_ff[WORD_BITS-1]) begin
            carry_in = CNT_W'((CNT_W+1)'(carry_ff) + (CNT_W+1)'(WORD_BITS));
         end else begin
            carry_in = CNT_W'(s1_rl_ff[WORD_BITS-1]);
         end
      end else begin
         carry_in = carry_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   assign res.valid   = out_valid;
   assign res.hit     = |hit;
   assign res.word    = s1_word_ff;
   assign res.end_idx = {s1_word_ff, pos};

endmodule

// ===== hdl/bitmap_frame_allocator.sv =====
// bitmap frame allocator: one free bit per 4 KiB frame, held in 64 bit words in a
// single-port-read, single-port-write map memory. the map resets to all used and
// software frees the usable frames. after reset the block sweeps the memory to zero,
// one word per cycle (MAX_FRAMES/64 words, 512 by default) with busy high;
// configuration writes are taken meanwhile. an item is taken when start is high and
// busy low; its single result word appears later on the rsp_ ports for exactly one
// cycle with rsp_valid high and must be captured then, there is no stall.
// sequencing, set by the one read port of the map memory (one word per cycle):
// a free checks the address, reads the word and writes it back; an allocation with a
// bad count fails at the check; an allocation reads the map words in order through a
// two stage run search, all W words when no run fits (W = ceil(total/64)), and when
// it fits the S words scanned up to the hit, then the C words the run spans, which
// are read, cleared and written back at one word per cycle.
module bitmap_frame_allocator
   import bfa_pkg::*;
#(
   parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_kind,
   input  logic [CNT_W-1:0]     req_count,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_valid,
   output logic [ADDR_W-1:0]    rsp_result_address,
   output logic [1:0]           rsp_status,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_ACHK  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_FILL  = 7'b0010000,
      S_FCHK  = 7'b0100000,
      S_FWR   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [ADDR_W-1:0] base_ff;
   logic [CNT_W-1:0]  ftotal_ff;
   logic [IDX_W-1:0]  total;

   // latched request
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // map sweep and read pointer
   logic [MAP_AW-1:0] clr_ff, clr_in;
   logic [WRD_W-1:0]  rptr_ff, rptr_in;
   logic              issue_ff, issue_in;
   logic              rdv_scan_ff, rdv_fill_ff;
   logic [WRD_W-1:0]  rdw_ff;

   // run being claimed, frame being freed
   logic [IDX_W-1:0]  start_ff, start_in;
   logic [IDX_W-1:0]  end_ff, end_in;
   logic [IDX_W-1:0]  fidx_ff, fidx_in;

   // result word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff, rsp_status_in;

   // memory port
   logic                 rd_en;
   logic [WRD_W-1:0]     rd_word;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [MAP_AW-1:0]    wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   scan_res_type         scan;

   logic [WRD_W-1:0]     last_word;
   logic [IDX_W-1:0]     hit_start;
   logic [ADDR_W-1:0]    off;
   logic                 free_ok;
   logic [BIT_W-1:0]     clr_lo, clr_hi;
   logic [WORD_BITS-1:0] fill_mask;

   // frames managed: the frame total register, capped at the map size
   assign total = (32'(ftotal_ff) < MAX_FRAMES) ? ftotal_ff : IDX_W'(MAX_FRAMES);

   // highest word that holds a managed frame
   assign last_word = WRD_W'((total - 1'b1) >> BIT_W);

   // first frame of the run that ends at the hit
   assign hit_start = scan.end_idx - count_ff + 1'b1;

   // free range check, no wrap at the top
   assign off     = addr_ff - base_ff;
   assign free_ok = (addr_ff != '0) && (addr_ff >= base_ff) &&
                    (off < (ADDR_W'(total) << FRAME_SHIFT));

   // bits of the current word that belong to the claimed run
   assign clr_lo    = (rdw_ff == start_ff[IDX_W-1:BIT_W]) ? start_ff[BIT_W-1:0] : '0;
   assign clr_hi    = (rdw_ff == end_ff[IDX_W-1:BIT_W]) ? end_ff[BIT_W-1:0] : '1;
   assign fill_mask = ({WORD_BITS{1'b1}} << clr_lo) &
                      ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - clr_hi));

   bfa_map_ram #(
      .DEPTH (MAP_WORDS),
      .AW    (MAP_AW)
   ) u_map (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (MAP_AW'(rd_word)),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   bfa_run_finder u_finder (
      .clock    (clock),
      .reset    (reset),
      .active   (state_ff == S_SCAN),
      .in_valid (rdv_scan_ff),
      .in_word  (rdw_ff),
      .in_data  (rd_data),
      .total    (total),
      .count    (count_ff),
      .res      (scan)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      addr_in       = addr_ff;
      clr_in        = clr_ff;
      rptr_in       = rptr_ff;
      issue_in      = issue_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      fidx_in       = fidx_ff;
      rsp_valid_in  = 1'b0;
      rsp_addr_in   = '0;
      rsp_status_in = rsp_status_ff;
      rd_en         = 1'b0;
      rd_word       = rptr_ff;
      wr_en         = 1'b0;
      wr_addr       = MAP_AW'(rdw_ff);
      wr_data       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            // sweep the map to all used
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == MAP_AW'(MAP_WORDS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               count_in = req_count;
               addr_in  = req_address;
               state_in = (req_kind == KIND_FREE) ? S_FCHK : S_ACHK;
            end
         end
         S_ACHK: begin
            if (count_ff == '0 || count_ff > total) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ALLOC_FAIL;
               state_in      = S_IDLE;
            end else begin
               rptr_in  = '0;
               issue_in = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // stream words into the run search
            if (issue_ff) begin
               rd_en   = 1'b1;
               rptr_in = rptr_ff + 1'b1;
               if (rptr_ff == last_word) begin
                  issue_in = 1'b0;
               end
            end
            if (scan.valid && scan.hit) begin
               start_in = hit_start;
               end_in   = scan.end_idx;
               rptr_in  = hit_start[IDX_W-1:BIT_W];
               issue_in = 1'b1;
               state_in = S_FILL;
            end else if (scan.valid && scan.word == last_word) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ALLOC_FAIL;
               state_in      = S_IDLE;
            end
         end
         S_FILL: begin
            // read, clear the run bits, write back: one word per cycle
            if (issue_ff) begin
               rd_en   = 1'b1;
               rptr_in = rptr_ff + 1'b1;
               if (rptr_ff == end_ff[IDX_W-1:BIT_W]) begin
                  issue_in = 1'b0;
               end
            end
            if (rdv_fill_ff) begin
               wr_en   = 1'b1;
               wr_addr = MAP_AW'(rdw_ff);
               wr_data = rd_data & ~fill_mask;
               if (rdw_ff == end_ff[IDX_W-1:BIT_W]) begin
                  rsp_valid_in  = 1'b1;
                  rsp_addr_in   = base_ff + (ADDR_W'(start_ff) << FRAME_SHIFT);
                  rsp_status_in = ST_ALLOCATED;
                  state_in      = S_IDLE;
               end
            end
         end
         S_FCHK: begin
            if (free_ok) begin
               fidx_in  = off[FRAME_SHIFT +: IDX_W];
               rd_en    = 1'b1;
               rd_word  = off[FRAME_SHIFT + BIT_W +: WRD_W];
               state_in = S_FWR;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FREE_IGNORED;
               state_in      = S_IDLE;
            end
         end
         S_FWR: begin
            // word read last cycle, set the frame bit
            wr_en         = 1'b1;
            wr_addr       = MAP_AW'(fidx_ff[IDX_W-1:BIT_W]);
            wr_data       = rd_data | (WORD_BITS'(1) << fidx_ff[BIT_W-1:0]);
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FREED;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         rdv_scan_ff  <= 1'b0;
         rdv_fill_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         ftotal_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         rdv_scan_ff  <= rd_en && (state_ff == S_SCAN);
         rdv_fill_ff  <= rd_en && (state_ff == S_FILL);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               REG_BASE_ADDRESS: base_ff   <= csr_data;
               REG_FRAME_TOTAL:  ftotal_ff <= csr_data[CNT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      addr_ff       <= addr_in;
      rptr_ff       <= rptr_in;
      rdw_ff        <= rd_word;
      start_ff      <= start_in;
      end_ff        <= end_in;
      fidx_ff       <= fidx_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;

endmodule
